// ===== sv/mmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// mmhq_pkg
// Shared types, command codes and helpers for the min-max heap queue.
// ----------------------------------------------------------------------------
package mmhq_pkg;

    localparam int unsigned CAPACITY = 1023;
    localparam int unsigned ADDR_W   = 10;
    localparam int unsigned DEPTH    = 1 << ADDR_W;
    localparam int unsigned CAND_W   = ADDR_W + 2;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_DEL_MIN = 2'd1;
    localparam logic [1:0] CMD_DEL_MAX = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_PRD,
        ST_INS_PCMP,
        ST_INS_GRD,
        ST_INS_GCMP,
        ST_PLACE,
        ST_DEL_LRD,
        ST_DEL_LCAP,
        ST_DEL_2RD,
        ST_DEL_3RD,
        ST_DEL_3CAP,
        ST_DEL_SLOT,
        ST_TD_CHK,
        ST_TD_CRD,
        ST_TD_CCAP,
        ST_TD_DEC,
        ST_TD_PRD,
        ST_TD_PCMP,
        ST_REP1,
        ST_REP2,
        ST_REP3,
        ST_REP4,
        ST_DONE
    } t_state;

    // a beats b: greater in max mode, smaller in min mode
    function automatic logic beats(input logic signed [31:0] a,
                                   input logic signed [31:0] b,
                                   input logic maxm);
        beats = maxm ? (a > b) : (a < b);
    endfunction

    // slot on a min level when the index of its top set bit is even
    function automatic logic on_min_level(input logic [ADDR_W-1:0] idx);
        logic lvl_odd;
        lvl_odd = 1'b0;
        for (int b = 1; b < ADDR_W; b++) begin
            if (idx[b]) begin
                lvl_odd = b[0];
            end
        end
        on_min_level = !lvl_odd;
    endfunction

    // candidates: left child, right child, then four grandchildren
    function automatic logic [CAND_W-1:0] cand_addr(input logic [ADDR_W-1:0] idx,
                                                    input logic [2:0] k);
        logic [CAND_W-1:0] base;
        base = {2'b00, idx};
        if (k < 3'd2) begin
            cand_addr = (base << 1) + CAND_W'(k);
        end else begin
            cand_addr = (base << 2) + CAND_W'(k - 3'd2);
        end
    endfunction

endpackage

// ===== sv/min_max_heap_queue_core.sv =====
// ----------------------------------------------------------------------------
// min_max_heap_queue_core
// Double-ended priority queue kept as a min-max heap in one synchronous RAM.
// ----------------------------------------------------------------------------
// Each command beat (insert, delete-min, delete-max, clear) is run to the end
// before the next one is taken, and yields one status beat with the current
// minimum, maximum, count, empty flag and a drop flag. All heap slots sit in
// a single 1024 x 32 RAM with one read and one write port and a registered
// read. After the accept cycle, an insert checks the parent, climbs past
// grandparents while the value beats them, and places the value; a delete
// reads the last entry (and slots 2 and 3 for delete-max with three or more
// entries) to pick the slot, then walks down one level pair per pass, reading
// up to six descendants. Every command ends with status reads and the result
// load. A result that waits on the output register holds the input off. The
// RAM needs no clearing.
// ----------------------------------------------------------------------------
module min_max_heap_queue_core
    import mmhq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] key
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata    // [31:0] min_value, [63:32] max_value,
                                          // [73:64] size, [74] is_empty,
                                          // [75] ignored, [79:76] zero
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic               mem_we;
    logic signed [31:0] wr_data;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_fill, n_fill;
    logic [ADDR_W-1:0]  r_i, n_i;
    logic [ADDR_W-1:0]  r_m, n_m;
    logic signed [31:0] r_v, n_v;
    logic signed [31:0] r_bm, n_bm;
    logic signed [31:0] r_h2, n_h2;
    logic signed [31:0] r_min, n_min;
    logic signed [31:0] r_max, n_max;
    logic               r_mode, n_mode;
    logic               r_ign, n_ign;
    logic               r_gc, n_gc;
    logic [1:0]         r_slot, n_slot;
    logic [2:0]         r_k, n_k;
    logic               r_out_valid, n_out_valid;
    logic [79:0]        r_out_data, n_out_data;

    logic               s_acc;
    logic [CAND_W-1:0]  cur_cand, nxt_cand;
    logic [2:0]         k_next;
    logic [ADDR_W-1:0]  fill_dec;
    logic               par_swap, gp_swap, cand_take, td_gc_go, td_ch_go, td_par_go;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign cur_cand = cand_addr(r_i, r_k);
    assign k_next   = r_k + 3'd1;
    assign nxt_cand = cand_addr(r_i, k_next);
    assign fill_dec = r_fill - ADDR_W'(1);

    assign par_swap  = on_min_level(r_i) ? (r_v > r_rd_data) : (r_v < r_rd_data);
    assign gp_swap   = beats(r_v, r_rd_data, r_mode);
    assign cand_take = (r_k == 3'd0) || beats(r_rd_data, r_bm, r_mode);
    assign td_gc_go  = r_gc && beats(r_bm, r_v, r_mode);
    assign td_ch_go  = !r_gc && beats(r_bm, r_v, r_mode);
    assign td_par_go = beats(r_rd_data, r_v, r_mode);

    // next state and working registers
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_i         = r_i;
        n_m         = r_m;
        n_v         = r_v;
        n_bm        = r_bm;
        n_h2        = r_h2;
        n_min       = r_min;
        n_max       = r_max;
        n_mode      = r_mode;
        n_ign       = r_ign;
        n_gc        = r_gc;
        n_slot      = r_slot;
        n_k         = r_k;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_ign  = 1'b0;
                    n_v    = i_s_axis_tdata;
                    n_mode = (i_s_axis_tuser == CMD_DEL_MAX);
                    case (i_s_axis_tuser)
                        CMD_INSERT: begin
                            if ({22'd0, r_fill} >= CAPACITY) begin
                                n_ign   = 1'b1;
                                n_state = ST_REP1;
                            end else begin
                                n_fill  = r_fill + ADDR_W'(1);
                                n_i     = r_fill + ADDR_W'(1);
                                n_state = (r_fill == '0) ? ST_PLACE : ST_INS_PRD;
                            end
                        end
                        CMD_DEL_MIN, CMD_DEL_MAX: begin
                            if (r_fill == '0) begin
                                n_ign   = 1'b1;
                                n_state = ST_REP1;
                            end else begin
                                n_state = ST_DEL_LRD;
                            end
                        end
                        default: begin
                            n_fill  = '0;
                            n_state = ST_REP1;
                        end
                    endcase
                end
            end
            ST_INS_PRD: n_state = ST_INS_PCMP;
            ST_INS_PCMP: begin
                if (par_swap) begin
                    n_i    = r_i >> 1;
                    n_mode = on_min_level(r_i);
                end else begin
                    n_mode = !on_min_level(r_i);
                end
                n_state = ST_INS_GRD;
            end
            ST_INS_GRD: n_state = (r_i < ADDR_W'(4)) ? ST_PLACE : ST_INS_GCMP;
            ST_INS_GCMP: begin
                if (gp_swap) begin
                    n_i     = r_i >> 2;
                    n_state = ST_INS_GRD;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_PLACE: n_state = ST_REP1;
            ST_DEL_LRD: n_state = ST_DEL_LCAP;
            ST_DEL_LCAP: begin
                n_v = r_rd_data;
                if (!r_mode || r_fill == ADDR_W'(1)) begin
                    n_slot  = 2'd1;
                    n_state = ST_DEL_SLOT;
                end else if (r_fill == ADDR_W'(2)) begin
                    n_slot  = 2'd2;
                    n_state = ST_DEL_SLOT;
                end else begin
                    n_state = ST_DEL_2RD;
                end
            end
            ST_DEL_2RD: n_state = ST_DEL_3RD;
            ST_DEL_3RD: begin
                n_h2    = r_rd_data;
                n_state = ST_DEL_3CAP;
            end
            ST_DEL_3CAP: begin
                n_slot  = (r_h2 > r_rd_data) ? 2'd2 : 2'd3;
                n_state = ST_DEL_SLOT;
            end
            ST_DEL_SLOT: begin
                n_fill = fill_dec;
                n_i    = {8'd0, r_slot};
                n_state = ({8'd0, r_slot} <= fill_dec) ? ST_TD_CHK : ST_REP1;
            end
            ST_TD_CHK: begin
                n_k = 3'd0;
                n_state = ({r_i, 1'b0} > {1'b0, r_fill}) ? ST_PLACE : ST_TD_CRD;
            end
            ST_TD_CRD: n_state = ST_TD_CCAP;
            ST_TD_CCAP: begin
                if (cand_take) begin
                    n_bm = r_rd_data;
                    n_m  = cur_cand[ADDR_W-1:0];
                    n_gc = (r_k >= 3'd2);
                end
                n_k = k_next;
                if (r_k < 3'd5 && nxt_cand <= {2'b00, r_fill}) begin
                    n_state = ST_TD_CRD;
                end else begin
                    n_state = ST_TD_DEC;
                end
            end
            ST_TD_DEC: begin
                if (td_gc_go) begin
                    n_i     = r_m;
                    n_state = ST_TD_PRD;
                end else if (td_ch_go) begin
                    n_i     = r_m;
                    n_state = ST_PLACE;
                end else begin
                    n_state = ST_PLACE;
                end
            end
            ST_TD_PRD: n_state = ST_TD_PCMP;
            ST_TD_PCMP: begin
                if (td_par_go) begin
                    n_v = r_rd_data;
                end
                n_state = ST_TD_CHK;
            end
            ST_REP1: begin
                if (r_fill == '0) begin
                    n_min   = '0;
                    n_max   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_REP2;
                end
            end
            ST_REP2: begin
                n_min = r_rd_data;
                n_max = r_rd_data;
                n_state = (r_fill == ADDR_W'(1)) ? ST_DONE : ST_REP3;
            end
            ST_REP3: begin
                n_h2  = r_rd_data;
                n_max = r_rd_data;
                n_state = (r_fill == ADDR_W'(2)) ? ST_DONE : ST_REP4;
            end
            ST_REP4: begin
                n_max   = (r_h2 > r_rd_data) ? r_h2 : r_rd_data;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'd0, r_ign, (r_fill == '0), r_fill, r_max, r_min};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // RAM port controls
    always_comb begin
        rd_addr = '0;
        wr_addr = r_i;
        wr_data = r_v;
        mem_we  = 1'b0;
        case (r_state)
            ST_INS_PRD:  rd_addr = r_i >> 1;
            ST_INS_PCMP: begin
                mem_we  = par_swap;
                wr_data = r_rd_data;
            end
            ST_INS_GRD:  rd_addr = r_i >> 2;
            ST_INS_GCMP: begin
                mem_we  = gp_swap;
                wr_data = r_rd_data;
            end
            ST_PLACE:    mem_we = 1'b1;
            ST_DEL_LRD:  rd_addr = r_fill;
            ST_DEL_2RD:  rd_addr = ADDR_W'(2);
            ST_DEL_3RD:  rd_addr = ADDR_W'(3);
            ST_TD_CRD:   rd_addr = cur_cand[ADDR_W-1:0];
            ST_TD_DEC: begin
                mem_we  = td_gc_go || td_ch_go;
                wr_data = r_bm;
            end
            ST_TD_PRD:   rd_addr = r_i >> 1;
            ST_TD_PCMP: begin
                // parent of the new hole takes the sifted value
                mem_we  = td_par_go;
                wr_addr = r_i >> 1;
            end
            ST_REP1:     rd_addr = ADDR_W'(1);
            ST_REP2:     rd_addr = ADDR_W'(2);
            ST_REP3:     rd_addr = ADDR_W'(3);
            default:     rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_m        <= n_m;
        r_v        <= n_v;
        r_bm       <= n_bm;
        r_h2       <= n_h2;
        r_min      <= n_min;
        r_max      <= n_max;
        r_mode     <= n_mode;
        r_ign      <= n_ign;
        r_gc       <= n_gc;
        r_slot     <= n_slot;
        r_k        <= n_k;
        r_out_data <= n_out_data;
    end

`ifndef SYNTHESIS
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {22'd0, r_fill} <= CAPACITY)
        else $error("fill count above capacity");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && i_s_axis_tuser == CMD_INSERT && {22'd0, r_fill} < CAPACITY
        |=> r_fill == $past(r_fill) + ADDR_W'(1))
        else $error("insert did not grow the heap");

    a_idle_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !mem_we)
        else $error("RAM written while idle");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[74] == (r_out_data[73:64] == '0)))
        else $error("empty flag disagrees with size");
`endif

endmodule
